[sv/hdf_pkg.sv]
// hdf_pkg: types, character codes and helpers for the hex digit formatter
// no dependencies; used by every file of the block

package hdf_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned NIBBLE_W = 4;
    localparam int unsigned CNT_W    = 3;

    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_X        = 8'h78;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_NONE     = 8'h00;

    localparam logic [2:0] WIDTH_BYTE  = 3'd1;
    localparam logic [2:0] WIDTH_HALF  = 3'd2;
    localparam logic [2:0] WIDTH_WORD  = 3'd4;

    localparam logic [1:0] CASE_LOWER  = 2'd0;
    localparam logic [1:0] CASE_UPPER  = 2'd1;

    localparam logic [NIBBLE_W-1:0] DIGIT_TEN = 4'd10;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  byte_width;
        logic [1:0]  format_flags;
        logic [1:0]  letter_case;
    } cmd_t;

    typedef struct packed {
        logic [7:0] character;
        logic       char_valid;
        logic       last;
        logic       error;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PFX_ZERO,
        ST_PFX_X,
        ST_DIGITS,
        ST_ERROR
    } state_t;

    // controller to nibble shift register
    typedef struct packed {
        logic       load;
        logic       shift;
        logic [2:0] byte_width;
    } sreg_ctl_t;

    // nibble shift register back to controller
    typedef struct packed {
        logic [NIBBLE_W-1:0] nibble;
        logic                last_digit;
    } sreg_stat_t;

    function automatic logic [7:0] digit_char(input logic [NIBBLE_W-1:0] d,
                                              input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (d < DIGIT_TEN)
            digit_char = CHAR_ZERO + {4'd0, d};
        else
            digit_char = base + {4'd0, d - DIGIT_TEN};
    endfunction

endpackage

[sv/hdf_nibble_sreg.sv]
// hdf_nibble_sreg: value shift register, one hex digit per cycle while shift is set, msb first
// depends on hdf_pkg

module hdf_nibble_sreg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hdf_pkg::sreg_ctl_t     ctl,
    input  logic [31:0]            load_value,
    output hdf_pkg::sreg_stat_t    stat
);

    logic [hdf_pkg::VALUE_W-1:0] data_reg, data_next;
    logic [hdf_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        data_next = data_reg;
        cnt_next  = cnt_reg;
        if (ctl.load)
        begin
            // align the top digit of the chosen width to the msb end
            unique case (ctl.byte_width)
                hdf_pkg::WIDTH_BYTE:
                begin
                    data_next = {load_value[7:0], 24'd0};
                    cnt_next  = 3'd1;
                end
                hdf_pkg::WIDTH_HALF:
                begin
                    data_next = {load_value[15:0], 16'd0};
                    cnt_next  = 3'd3;
                end
                default:
                begin
                    data_next = load_value;
                    cnt_next  = 3'd7;
                end
            endcase
        end
        else if (ctl.shift)
        begin
            data_next = {data_reg[hdf_pkg::VALUE_W-hdf_pkg::NIBBLE_W-1:0],
                         {hdf_pkg::NIBBLE_W{1'b0}}};
            cnt_next  = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    assign stat.nibble     = data_reg[hdf_pkg::VALUE_W-1 -: hdf_pkg::NIBBLE_W];
    assign stat.last_digit = (cnt_reg == '0);

endmodule

[sv/hex_digit_formatter.sv]
// hex_digit_formatter: beats are registered from the sequencer state, with gaps for skipped leading zeros
// busy stays high from acceptance until the last beat: an optional 0x prefix, then the digits
// of the chosen width (2, 4 or 8) held in the nibble shift register, or a single error beat;
// leading zero digits are spent as silent cycles; the next item may be taken as the last beat shows
// results are registered strobe beats; the receiver cannot stall them
// rst_n asynchronously returns the sequencer to idle and clears the strobe

module hex_digit_formatter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  hdf_pkg::cmd_t     item,
    output logic              strobe,
    output hdf_pkg::result_t  result
);

    hdf_pkg::state_t     state_reg, state_next;
    logic                started_reg, started_next;   // digits go out: zero padding is set or a digit has been sent
    logic                upper_reg, upper_next;
    logic                width_ok_reg, width_ok_next;
    logic                strobe_reg, strobe_next;
    hdf_pkg::result_t    result_reg, result_next;
    hdf_pkg::sreg_ctl_t  sctl;
    hdf_pkg::sreg_stat_t sstat;
    logic                accept;
    logic                bad_case;
    logic                bad_width;
    logic                emit_digit;

    hdf_nibble_sreg u_sreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sctl),
        .load_value (item.value),
        .stat       (sstat)
    );

    assign busy   = (state_reg != hdf_pkg::ST_IDLE);
    assign accept = start && !busy;

    assign bad_case  = (item.letter_case != hdf_pkg::CASE_LOWER) &&
                       (item.letter_case != hdf_pkg::CASE_UPPER);
    assign bad_width = (item.byte_width != hdf_pkg::WIDTH_BYTE) &&
                       (item.byte_width != hdf_pkg::WIDTH_HALF) &&
                       (item.byte_width != hdf_pkg::WIDTH_WORD);

    // a digit goes out once a non-zero one is seen or zero padding is set, and the last always does
    assign emit_digit = started_reg || (sstat.nibble != '0) || sstat.last_digit;

    always_comb
    begin
        state_next      = state_reg;
        started_next    = started_reg;
        upper_next      = upper_reg;
        width_ok_next   = width_ok_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        sctl.load       = 1'b0;
        sctl.shift      = 1'b0;
        sctl.byte_width = item.byte_width;

        unique case (state_reg)
            hdf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    sctl.load     = 1'b1;
                    upper_next    = (item.letter_case == hdf_pkg::CASE_UPPER);
                    width_ok_next = !bad_width;
                    // zero padding looks at the whole word, so zero is never padded
                    started_next  = item.format_flags[0] && (item.value != '0);
                    if (bad_case)
                        state_next = hdf_pkg::ST_ERROR;
                    else if (item.format_flags[1])
                        state_next = hdf_pkg::ST_PFX_ZERO;
                    else if (bad_width)
                        state_next = hdf_pkg::ST_ERROR;
                    else
                        state_next = hdf_pkg::ST_DIGITS;
                end
            end
            hdf_pkg::ST_PFX_ZERO:
            begin
                strobe_next = 1'b1;
                result_next = '{character: hdf_pkg::CHAR_ZERO, char_valid: 1'b1,
                                last: 1'b0, error: 1'b0};
                state_next  = hdf_pkg::ST_PFX_X;
            end
            hdf_pkg::ST_PFX_X:
            begin
                strobe_next = 1'b1;
                result_next = '{character: hdf_pkg::CHAR_X, char_valid: 1'b1,
                                last: 1'b0, error: 1'b0};
                state_next  = width_ok_reg ? hdf_pkg::ST_DIGITS : hdf_pkg::ST_ERROR;
            end
            hdf_pkg::ST_DIGITS:
            begin
                sctl.shift = 1'b1;
                if (emit_digit)
                begin
                    strobe_next  = 1'b1;
                    started_next = 1'b1;
                    result_next  = '{character: hdf_pkg::digit_char(sstat.nibble, upper_reg),
                                     char_valid: 1'b1, last: sstat.last_digit,
                                     error: 1'b0};
                end
                if (sstat.last_digit)
                    state_next = hdf_pkg::ST_IDLE;
            end
            hdf_pkg::ST_ERROR:
            begin
                strobe_next = 1'b1;
                result_next = '{character: hdf_pkg::CHAR_NONE, char_valid: 1'b0,
                                last: 1'b1, error: 1'b1};
                state_next  = hdf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = hdf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hdf_pkg::ST_IDLE;
            started_reg  <= 1'b0;
            strobe_reg   <= 1'b0;
            upper_reg    <= 1'b0;
            width_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            started_reg  <= started_next;
            strobe_reg   <= strobe_next;
            upper_reg    <= upper_next;
            width_ok_reg <= width_ok_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

[sv/hdf_checker.sv]
// hdf_checker: port-level assertions for hex_digit_formatter, bound to the top level
// depends on hdf_pkg and hex_digit_formatter

module hdf_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             strobe,
    input hdf_pkg::result_t result
);

    // an accepted command always raises busy in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // the closing beat of a command leaves the block free
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |-> !busy)
        else $error("busy still high on last beat");

    // a beat that is not the last means more are coming
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("busy low before last beat");

    // error beats close the command and carry no character
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.error |-> result.last && !result.char_valid &&
                                   (result.character == hdf_pkg::CHAR_NONE))
        else $error("malformed error beat");

    // every beat is either a character or an error
    a_beat_kind: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.char_valid != result.error))
        else $error("beat is neither character nor error");

endmodule

bind hex_digit_formatter hdf_checker u_hdf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
